// ===== rtl/rgfd_pkg.sv =====
package rgfd_pkg;

   // sizing of the row scan
   localparam int MAX_SITES      = 4096;
   localparam int MAX_ROWS       = 1024;
   localparam int FILLER_TYPES   = 6;

   localparam int SITE_W         = $clog2(MAX_SITES);
   localparam int LEN_W          = SITE_W + 1;
   localparam int ROW_W          = $clog2(MAX_ROWS);
   localparam int WIDTH_W        = 8;
   localparam int TYPE_W         = 3;
   localparam int COUNT_W        = 13;
   localparam int CSR_IDX_W      = 3;

   // gap queue between scan and split
   localparam int GAP_FIFO_DEPTH = 4;
   localparam int GAP_PTR_W      = $clog2(GAP_FIFO_DEPTH);
   localparam int GAP_CNT_W      = $clog2(GAP_FIFO_DEPTH + 1);

   // restoring divider steps, one quotient bit per cycle
   localparam int DIV_STEPS      = LEN_W;
   localparam int DIV_STEP_W     = $clog2(DIV_STEPS);

   // one closed gap as handed from scan to split
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [SITE_W-1:0] start;
      logic [LEN_W-1:0]  len;
   } gap_type;

   // configured filler widths, index 0 first
   typedef logic [FILLER_TYPES-1:0][WIDTH_W-1:0] widths_type;

   // one result beat
   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [SITE_W-1:0]  start;
      logic [TYPE_W-1:0]  ftype;
      logic [COUNT_W-1:0] count;
      logic               error;
      logic               last;
   } result_type;

endpackage

// ===== rtl/rgfd_scan.sv =====
module rgfd_scan
   import rgfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_occupied,
   input  logic [ROW_W-1:0]  req_row_index,
   input  logic              req_last_site,
   output logic              gap_valid,
   input  logic              gap_ready,
   output gap_type           gap_data
);

   logic [SITE_W-1:0] pos_ff, pos_in;
   logic [SITE_W-1:0] gap_start_ff, gap_start_in;
   logic [ROW_W-1:0]  gap_row_ff, gap_row_in;
   logic              in_gap_ff, in_gap_in;

   logic              accept;
   logic              open_gap;
   logic              gap_live;
   logic              close_gap;
   logic [SITE_W-1:0] start_eff;
   logic [ROW_W-1:0]  row_eff;
   logic [LEN_W-1:0]  end_site;
   logic [LEN_W-1:0]  gap_len;

   // the queue must have room for any beat that may close a gap
   assign req_ready = gap_ready;
   assign accept    = req_valid && req_ready;

   // gap tracking for the current site
   always_comb begin
      open_gap  = !req_occupied && !in_gap_ff;
      gap_live  = in_gap_ff || !req_occupied;
      start_eff = open_gap ? pos_ff : gap_start_ff;
      row_eff   = open_gap ? req_row_index : gap_row_ff;
      close_gap = gap_live && (req_occupied || req_last_site);
      end_site  = req_occupied ? {1'b0, pos_ff} : ({1'b0, pos_ff} + LEN_W'(1));
      gap_len   = end_site - {1'b0, start_eff};
   end

   // a closed gap of zero length (saturated counter) produces nothing
   assign gap_valid      = req_valid && close_gap && (gap_len != '0);
   assign gap_data.row   = row_eff;
   assign gap_data.start = start_eff;
   assign gap_data.len   = gap_len;

   // next state of the site scan
   always_comb begin
      pos_in       = pos_ff;
      gap_start_in = gap_start_ff;
      gap_row_in   = gap_row_ff;
      in_gap_in    = in_gap_ff;
      if (accept) begin
         gap_start_in = start_eff;
         gap_row_in   = row_eff;
         in_gap_in    = gap_live && !close_gap && !req_last_site;
         if (req_last_site) begin
            pos_in = '0;
         end else if (pos_ff != SITE_W'(MAX_SITES - 1)) begin
            pos_in = pos_ff + SITE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         gap_start_ff <= '0;
         gap_row_ff   <= '0;
         in_gap_ff    <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         gap_start_ff <= gap_start_in;
         gap_row_ff   <= gap_row_in;
         in_gap_ff    <= in_gap_in;
      end
   end

endmodule

// ===== rtl/rgfd_fifo.sv =====
module rgfd_fifo
   import rgfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  gap_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output gap_type out_data
);

   gap_type                entry_ff [GAP_FIFO_DEPTH];
   logic [GAP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [GAP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [GAP_CNT_W-1:0]   count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = (count_ff != GAP_CNT_W'(GAP_FIFO_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + GAP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + GAP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + GAP_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - GAP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/rgfd_split.sv =====
module rgfd_split
   import rgfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  widths_type widths,
   input  logic       gap_valid,
   output logic       gap_ready,
   input  gap_type    gap_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   typedef enum logic [4:0] {
      SP_IDLE  = 5'b00001,
      SP_SCAN  = 5'b00010,
      SP_DIV   = 5'b00100,
      SP_APPLY = 5'b01000,
      SP_EMIT  = 5'b10000
   } split_state_type;

   split_state_type        state_ff, state_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [SITE_W-1:0]      start_ff, start_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic [TYPE_W-1:0]      idx_ff, idx_in;
   logic [WIDTH_W-1:0]     rdiv_ff, rdiv_in;
   logic [LEN_W-1:0]       dq_ff, dq_in;
   logic [DIV_STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0]     count_ff [FILLER_TYPES];
   logic [COUNT_W-1:0]     count_in [FILLER_TYPES];
   logic [SITE_W-1:0]      run_start_ff [FILLER_TYPES];
   logic [SITE_W-1:0]      run_start_in [FILLER_TYPES];
   logic [TYPE_W-1:0]      last_type_ff, last_type_in;
   logic [TYPE_W-1:0]      emit_ff, emit_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_data_ff, out_data_in;

   logic                   have_one;
   logic [WIDTH_W-1:0]     w_cur;
   logic                   out_free;
   logic [WIDTH_W:0]       div_shift;
   logic                   div_ge;
   logic [COUNT_W-1:0]     apply_count;
   logic [LEN_W-1:0]       apply_rem;
   logic [LEN_W-1:0]       apply_off;
   logic [LEN_W-1:0]       apply_pos;

   // one-site fillers exist only if the last nonzero width is one
   always_comb begin
      logic [WIDTH_W-1:0] smallest;
      smallest = '0;
      for (int i = 0; i < FILLER_TYPES; i++) begin
         if (widths[i] != '0) begin
            smallest = widths[i];
         end
      end
      have_one = (smallest == WIDTH_W'(1));
   end

   assign w_cur     = (idx_ff < TYPE_W'(FILLER_TYPES)) ? widths[idx_ff] : '0;
   assign out_free  = !out_valid_ff || out_ready;
   assign gap_ready = (state_ff == SP_IDLE);
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // restoring divide step: remaining sites by the current width
   always_comb begin
      div_shift = {rdiv_ff, dq_ff[LEN_W-1]};
      div_ge    = (div_shift >= {1'b0, w_cur});
      rdiv_in   = div_ge ? WIDTH_W'(div_shift - {1'b0, w_cur}) : div_shift[WIDTH_W-1:0];
      dq_in     = {dq_ff[LEN_W-2:0], div_ge};
   end

   // greedy count for this type, stepping back on a one-site hole or a non-last width of one
   always_comb begin
      apply_count = COUNT_W'(dq_ff);
      apply_rem   = LEN_W'(rdiv_ff);
      if (!have_one && (rdiv_ff == WIDTH_W'(1)) && (dq_ff != '0)) begin
         apply_count = COUNT_W'(dq_ff - LEN_W'(1));
         apply_rem   = LEN_W'(rdiv_ff) + LEN_W'(w_cur);
      end else if (!have_one && (rdiv_ff == '0) && (w_cur == WIDTH_W'(1))
                   && (dq_ff >= LEN_W'(2))) begin
         apply_count = COUNT_W'(dq_ff - LEN_W'(2));
         apply_rem   = LEN_W'(2);
      end
      apply_off = len_ff - rem_ff;
      apply_pos = LEN_W'(start_ff) + apply_off;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      start_in     = start_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      run_start_in = run_start_ff;
      last_type_in = last_type_ff;
      emit_in      = emit_ff;
      out_valid_in = out_valid_ff && !out_ready;
      out_data_in  = out_data_ff;

      unique case (state_ff)
         SP_IDLE: begin
            if (gap_valid) begin
               row_in   = gap_data.row;
               start_in = gap_data.start;
               len_in   = gap_data.len;
               rem_in   = gap_data.len;
               idx_in   = '0;
               for (int i = 0; i < FILLER_TYPES; i++) begin
                  count_in[i] = '0;
               end
               state_in = SP_SCAN;
            end
         end
         SP_SCAN: begin
            if (rem_ff == '0) begin
               emit_in  = '0;
               state_in = SP_EMIT;
            end else if (idx_ff == TYPE_W'(FILLER_TYPES)) begin
               // gap cannot be filled: single error beat
               if (out_free) begin
                  out_valid_in      = 1'b1;
                  out_data_in.row   = row_ff;
                  out_data_in.start = start_ff;
                  out_data_in.ftype = '0;
                  out_data_in.count = '0;
                  out_data_in.error = 1'b1;
                  out_data_in.last  = 1'b1;
                  state_in          = SP_IDLE;
               end
            end else if (w_cur == '0) begin
               idx_in = idx_ff + TYPE_W'(1);
            end else begin
               step_in  = DIV_STEP_W'(DIV_STEPS - 1);
               state_in = SP_DIV;
            end
         end
         SP_DIV: begin
            if (step_ff == '0) begin
               state_in = SP_APPLY;
            end else begin
               step_in = step_ff - DIV_STEP_W'(1);
            end
         end
         SP_APPLY: begin
            count_in[idx_ff]     = apply_count;
            run_start_in[idx_ff] = apply_pos[SITE_W-1:0];
            if (apply_rem == '0) begin
               last_type_in = idx_ff;
            end
            rem_in   = apply_rem;
            idx_in   = idx_ff + TYPE_W'(1);
            state_in = SP_SCAN;
         end
         SP_EMIT: begin
            if (count_ff[emit_ff] == '0) begin
               emit_in = emit_ff + TYPE_W'(1);
            end else if (out_free) begin
               out_valid_in      = 1'b1;
               out_data_in.row   = row_ff;
               out_data_in.start = run_start_ff[emit_ff];
               out_data_in.ftype = emit_ff;
               out_data_in.count = count_ff[emit_ff];
               out_data_in.error = 1'b0;
               out_data_in.last  = (emit_ff == last_type_ff);
               if (emit_ff == last_type_ff) begin
                  state_in = SP_IDLE;
               end else begin
                  emit_in = emit_ff + TYPE_W'(1);
               end
            end
         end
         default: begin
            state_in = SP_IDLE;
         end
      endcase
   end

   // divider registers load from the remaining length on entry
   always_ff @(posedge clock) begin
      if (state_ff == SP_SCAN) begin
         rdiv_ff <= '0;
         dq_ff   <= rem_ff;
      end else if (state_ff == SP_DIV) begin
         rdiv_ff <= rdiv_in;
         dq_ff   <= dq_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SP_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      start_ff     <= start_in;
      len_ff       <= len_in;
      rem_ff       <= rem_in;
      idx_ff       <= idx_in;
      step_ff      <= step_in;
      count_ff     <= count_in;
      run_start_ff <= run_start_in;
      last_type_ff <= last_type_in;
      emit_ff      <= emit_in;
      out_data_ff  <= out_data_in;
   end

endmodule

// ===== rtl/row_gap_filler_decomposer.sv =====
// Row gap filler decomposer.
// Input channel (req_*): one beat per placement site, in row order, with the
// occupied bit, the row index and a last-site flag. Sites are taken one per
// cycle as long as the four-entry gap queue has room.
// Result channel (rsp_*): one beat per run of same-type fillers, with row,
// start site, type, count, error flag and last-of-gap. An unfillable gap gives
// a single beat with the error flag and last-of-gap set and a zero count.
// Configuration (csr_*): filler widths 0..5 are written by index, one per
// cycle; the user must write them only while the block is idle, as the block
// does not enforce it. Indexes past the last width are ignored.
// A closing site enters the queue in its own cycle. The splitter loads a gap,
// visits the filler slots in order, and for a nonzero width with sites left
// runs the serial divider and an update step. Once the gap is covered it
// walks the slots up to the last one used, else it sends the error beat. The
// serial divider sets the rate; the queue absorbs the sites between gaps.
// Reset: clears the scan position, the open gap, the queue, the widths, the
// splitter state and the output valid flag. A stalled receiver holds the
// output register, which stalls the splitter, then the queue, then req_ready.
module row_gap_filler_decomposer
   import rgfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_occupied,
   input  logic [ROW_W-1:0]     req_row_index,
   input  logic                 req_last_site,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ROW_W-1:0]     rsp_out_row,
   output logic [SITE_W-1:0]    rsp_start_site,
   output logic [TYPE_W-1:0]    rsp_filler_type,
   output logic [COUNT_W-1:0]   rsp_filler_count,
   output logic                 rsp_error_flag,
   output logic                 rsp_last_of_gap,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WIDTH_W-1:0]   csr_wdata
);

   widths_type widths_ff;
   widths_type widths_in;
   logic       scan_valid;
   logic       scan_ready;
   gap_type    scan_data;
   logic       queue_valid;
   logic       queue_ready;
   gap_type    queue_data;
   result_type result;

   // filler width registers
   always_comb begin
      widths_in = widths_ff;
      if (csr_write_enable && (csr_index < CSR_IDX_W'(FILLER_TYPES))) begin
         widths_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widths_ff <= '0;
      end else begin
         widths_ff <= widths_in;
      end
   end

   // site scan front end
   rgfd_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_occupied  (req_occupied),
      .req_row_index (req_row_index),
      .req_last_site (req_last_site),
      .gap_valid     (scan_valid),
      .gap_ready     (scan_ready),
      .gap_data      (scan_data)
   );

   // closed gaps waiting for the splitter
   rgfd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scan_valid),
      .in_ready  (scan_ready),
      .in_data   (scan_data),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_data)
   );

   // greedy splitter back end
   rgfd_split u_split (
      .clock     (clock),
      .reset     (reset),
      .widths    (widths_ff),
      .gap_valid (queue_valid),
      .gap_ready (queue_ready),
      .gap_data  (queue_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (result)
   );

   assign rsp_out_row      = result.row;
   assign rsp_start_site   = result.start;
   assign rsp_filler_type  = result.ftype;
   assign rsp_filler_count = result.count;
   assign rsp_error_flag   = result.error;
   assign rsp_last_of_gap  = result.last;

`ifndef SYNTHESIS
   // an error beat carries no fillers and closes its gap
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> (rsp_filler_count == '0) && rsp_last_of_gap)
      else $error("error beat with fillers or without last_of_gap");

   // a filled run always holds at least one filler
   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error_flag |-> (rsp_filler_count != '0))
      else $error("empty filler run reported");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
